// ===== rtl/core/positional_ordered_list_top_defines.svh =====
// Assertion macros used by the checker file of the positional ordered list.
// No dependencies; the macros expect a clock named i_clk and a reset i_rst_n.
`ifndef POSITIONAL_ORDERED_LIST_TOP_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_TOP_DEFINES_SVH

// Checked only while reset is released.
`define POL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, including during reset.
`define POL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/pol_pkg.sv =====
// Package for the positional ordered list: sizes, action and status codes.
// No dependencies.
`default_nettype none
package pol_pkg;
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int IDX_W    = ADDR_W + 1;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 40;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/pol_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module pol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/positional_ordered_list_top.sv =====
// Positional ordered list top level: sequencer around one entry RAM.
// Depends on pol_pkg and pol_ram.
`default_nettype none
// The block holds up to 16 signed 32-bit entries in list order in a small RAM.
// One beat on the input stream is one action; insert and delete each answer
// with one beat, read-out answers with one beat per entry (tlast on the final
// one) or one empty-status beat. Timing is set by the single RAM port pair:
// each entry moved takes a read state and a write state (S_INS_RD/S_INS_WR,
// S_DEL_RD/S_DEL_WR), so insert and delete take longer the nearer the
// position is to the head; a read-out visits S_RD_ISSUE and S_RD_EMIT per
// entry, a rejected action or an empty read-out goes straight to S_RD_EMIT,
// and stalls on the output stream add to the time an action takes.
// A new action is accepted once the previous one has handed its last result
// to the output register; that register lets the next action start while a
// result is still waiting downstream. No clearing pass is needed after reset.
module positional_ordered_list_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0: action[1:0], position[6:2], value[38:7], zero pad.
    input  wire logic [39:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // Fields from bit 0: status[1:0], item_value[33:2], element_count[38:34], pad.
    output logic      [39:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast
);
    import pol_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_INS_RD, S_INS_WR, S_DEL_GET, S_DEL_RD, S_DEL_WR, S_RD_ISSUE, S_RD_EMIT
    } t_state;

    // A RESP state would be one more member; rejected and finished actions
    // reuse S_RD_EMIT with r_resp set.
    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   r_pos_m1;
    logic [VAL_W-1:0]   r_val;
    logic [1:0]         r_status;
    logic               r_resp;

    logic [1:0]         w_action;
    logic [POS_W-1:0]   w_pos;
    logic [VAL_W-1:0]   w_value;
    logic               w_accept;
    logic               w_slot;
    logic               w_emit;
    logic [CNT_W:0]     w_cnt_p1;
    logic               w_ins_pos_ok;

    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic               w_re;
    logic [ADDR_W-1:0]  w_raddr;
    logic [VAL_W-1:0]   w_rdata;
    logic [IDX_W-1:0]   w_idx_m1;

    assign w_action = i_s_axis_tdata[1:0];
    assign w_pos    = i_s_axis_tdata[6:2];
    assign w_value  = i_s_axis_tdata[38:7];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot   = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_emit   = (r_state == S_RD_EMIT) && w_slot;
    assign w_cnt_p1 = {1'b0, r_count} + 1'b1;
    assign w_ins_pos_ok = (w_pos != '0) && ({1'b0, w_pos} <= w_cnt_p1);
    assign w_idx_m1 = r_idx - 1'b1;

    // RAM access for the current sequencer step.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[ADDR_W-1:0];
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = r_idx[ADDR_W-1:0];
        unique case (r_state)
            S_INS_RD: begin
                if (r_idx == r_pos_m1) begin
                    w_we    = 1'b1;
                    w_wdata = r_val;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_m1[ADDR_W-1:0];
                end
            end
            S_INS_WR: w_we = 1'b1;
            S_DEL_GET: begin
                w_re    = 1'b1;
                w_raddr = r_pos_m1[ADDR_W-1:0];
            end
            S_DEL_RD: w_re = (r_idx != IDX_W'(r_count));
            S_DEL_WR: begin
                w_we    = 1'b1;
                w_waddr = w_idx_m1[ADDR_W-1:0];
            end
            S_RD_ISSUE: w_re = 1'b1;
            default: ;
        endcase
    end

    pol_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_count         <= '0;
            r_resp          <= 1'b0;
            o_m_axis_tvalid <= 1'b0;
        end else begin
            if (w_emit) begin
                o_m_axis_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                o_m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pos_m1 <= IDX_W'(w_pos) - 1'b1;
                        unique case (w_action)
                            ACT_INSERT: begin
                                if (w_ins_pos_ok && r_count < CNT_W'(CAPACITY)) begin
                                    r_val   <= w_value;
                                    r_resp  <= 1'b0;
                                    r_idx   <= IDX_W'(r_count);
                                    r_state <= S_INS_RD;
                                end else begin
                                    // A rejected insert reports zero, like
                                    // every other rejected action.
                                    r_val    <= '0;
                                    r_resp   <= 1'b1;
                                    r_status <= w_ins_pos_ok ? ST_FULL : ST_INVALID;
                                    r_state  <= S_RD_EMIT;
                                end
                            end
                            ACT_DELETE: begin
                                r_val <= '0;
                                if (w_pos != '0 && w_pos <= r_count) begin
                                    r_resp  <= 1'b0;
                                    r_idx   <= IDX_W'(w_pos);
                                    r_state <= S_DEL_GET;
                                end else begin
                                    r_resp   <= 1'b1;
                                    r_status <= ST_INVALID;
                                    r_state  <= S_RD_EMIT;
                                end
                            end
                            ACT_READ: begin
                                r_val <= '0;
                                if (r_count == '0) begin
                                    r_resp   <= 1'b1;
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_RD_EMIT;
                                end else begin
                                    r_resp  <= 1'b0;
                                    r_idx   <= '0;
                                    r_state <= S_RD_ISSUE;
                                end
                            end
                            default: begin
                                r_val    <= '0;
                                r_resp   <= 1'b1;
                                r_status <= ST_INVALID;
                                r_state  <= S_RD_EMIT;
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (r_idx == r_pos_m1) begin
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_OK;
                        r_val    <= '0;
                        r_resp   <= 1'b1;
                        r_state  <= S_RD_EMIT;
                    end else begin
                        r_state <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    r_idx   <= w_idx_m1;
                    r_state <= S_INS_RD;
                end
                S_DEL_GET: r_state <= S_DEL_RD;
                S_DEL_RD: begin
                    // The deleted value is captured on the first visit, which
                    // follows the S_DEL_GET read.
                    if (r_idx == IDX_W'(r_pos_m1) + 1'b1) begin
                        r_val <= w_rdata;
                    end
                    if (r_idx == IDX_W'(r_count)) begin
                        r_count  <= r_count - 1'b1;
                        r_status <= ST_OK;
                        r_resp   <= 1'b1;
                        r_state  <= S_RD_EMIT;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_DEL_RD;
                end
                S_RD_ISSUE: r_state <= S_RD_EMIT;
                S_RD_EMIT: begin
                    if (w_slot) begin
                        if (r_resp) begin
                            o_m_axis_tdata <= {1'b0, r_count, r_val, r_status};
                            o_m_axis_tlast <= 1'b1;
                            r_state        <= S_IDLE;
                        end else begin
                            o_m_axis_tdata <= {1'b0, r_count, w_rdata, ST_OK};
                            o_m_axis_tlast <= (w_idx_m1 + 1'b1 == IDX_W'(r_count) - 1'b1);
                            r_idx          <= r_idx + 1'b1;
                            r_state        <= (r_idx + 1'b1 == IDX_W'(r_count)) ?
                                              S_IDLE : S_RD_ISSUE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/pol_checker.sv =====
// Port-level checker for the positional ordered list, bound to the top level.
// Depends on pol_pkg and positional_ordered_list_top_defines.svh.
`default_nettype none
`include "positional_ordered_list_top_defines.svh"
module pol_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tlast
);
    import pol_pkg::*;

    `POL_ASSERT(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "output beat changed while stalled")
    `POL_ASSERT(a_count_cap, o_m_axis_tvalid |-> o_m_axis_tdata[38:34] <= CNT_W'(CAPACITY), "element count above capacity")
    `POL_ASSERT(a_err_last, o_m_axis_tvalid && o_m_axis_tdata[1:0] != ST_OK |-> o_m_axis_tlast, "non-ok status without tlast")
    `POL_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_m_axis_tvalid, "output valid right after reset")
endmodule

bind positional_ordered_list_top pol_checker u_pol_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
`default_nettype wire

// ===== tb/tb_positional_ordered_list_top.sv =====
// Testbench for the positional ordered list: directed and random actions on the
// input stream, each output beat checked against a local list predictor.
// Depends on pol_pkg and positional_ordered_list_top.
`timescale 1ns / 100ps
`default_nettype none
module tb_positional_ordered_list_top;
    import pol_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // Fields from bit 0: action[1:0], position[6:2], value[38:7], zero pad.
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // Fields from bit 0: status[1:0], item_value[33:2], element_count[38:34], pad.
    logic [39:0] m_tdata;
    logic        m_tlast;

    // One expected output beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_value;
        logic [4:0]  element_count;
        logic        last;
    } t_list_beat;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         IDLE_LIMIT = 4000;

    t_list_beat  pending_beats[$];
    logic [31:0] list_vals[CAPACITY];
    int          list_len;
    int          error_count = 0;
    int          beats_checked = 0;
    int          actions_sent;
    int          idle_cycles = 0;
    bit          stall_enable;

    positional_ordered_list_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    task automatic push_beat(input logic [1:0] st, input logic [31:0] v, input logic fin);
        t_list_beat b;
        b.status        = st;
        b.item_value    = v;
        b.element_count = 5'(list_len);
        b.last          = fin;
        pending_beats.push_back(b);
    endtask

    // Applies one action to the local list and queues the beats it must produce.
    task automatic predict_action(input logic [1:0] act, input logic [4:0] pos,
                                  input logic [31:0] val);
        logic [31:0] taken;
        case (act)
            ACT_INSERT: begin
                if (pos < 1 || pos > list_len + 1) begin
                    push_beat(ST_INVALID, '0, 1'b1);
                end else if (list_len >= CAPACITY) begin
                    push_beat(ST_FULL, '0, 1'b1);
                end else begin
                    for (int i = list_len; i >= pos; i--) list_vals[i] = list_vals[i-1];
                    list_vals[pos-1] = val;
                    list_len++;
                    push_beat(ST_OK, '0, 1'b1);
                end
            end
            ACT_DELETE: begin
                if (pos < 1 || pos > list_len) begin
                    push_beat(ST_INVALID, '0, 1'b1);
                end else begin
                    taken = list_vals[pos-1];
                    for (int i = pos; i < list_len; i++) list_vals[i-1] = list_vals[i];
                    list_len--;
                    push_beat(ST_OK, taken, 1'b1);
                end
            end
            ACT_READ: begin
                if (list_len == 0) push_beat(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        push_beat(ST_OK, list_vals[i], i == list_len - 1);
            end
            default: push_beat(ST_INVALID, '0, 1'b1);
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("MISMATCH %s: got %h expected %h (beat %0d)", what, got, want,
                 beats_checked);
        error_count++;
    endtask

    // Sends one action beat, with a random gap ahead of it while stalls are on.
    // Valid stays high from one beat to the next unless a gap is inserted.
    task automatic send_action(input logic [1:0] act, input logic [4:0] pos,
                               input logic [31:0] val);
        if (stall_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_tdata  <= {1'b0, val, pos, act};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_action(act, pos, val);
        actions_sent++;
        @(negedge i_clk);
    endtask

    // Output ready: random stall bursts while enabled, always ready otherwise.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_enable && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Checks every accepted output beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            t_list_beat want;
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata, '0);
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", 40'(m_tdata[1:0]), 40'(want.status));
                if (m_tdata[33:2] !== want.item_value)
                    report_mismatch("item_value", 40'(m_tdata[33:2]),
                                    40'(want.item_value));
                if (m_tdata[38:34] !== want.element_count)
                    report_mismatch("element_count", 40'(m_tdata[38:34]),
                                    40'(want.element_count));
                if (m_tdata[39] !== 1'b0)
                    report_mismatch("pad", 40'(m_tdata[39]), '0);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", 40'(m_tlast), 40'(want.last));
            end
            beats_checked++;
        end
    end

    // Watchdog: too many cycles in a row with no beat on either side.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout with %0d beats pending", pending_beats.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Empty-list cases, bounds of position, fill to full, deletes at tail and head.
    task automatic test_directed();
        send_action(ACT_READ, 5'd0, 32'd0);
        send_action(ACT_DELETE, 5'd1, 32'd0);
        send_action(ACT_INSERT, 5'd0, 32'h1111_1111);
        send_action(ACT_INSERT, 5'd2, 32'h2222_2222);
        send_action(ACT_INSERT, 5'd1, 32'h8000_0000);
        send_action(ACT_INSERT, 5'd2, 32'h7FFF_FFFF);
        send_action(ACT_INSERT, 5'd1, 32'hFFFF_FFFF);
        send_action(ACT_UNUSED, 5'd1, 32'h5555_5555);
        send_action(ACT_READ, 5'd31, 32'hFFFF_FFFF);
        // Fill to capacity, then try further inserts at the tail and at the head.
        for (int i = 3; i <= CAPACITY; i++) send_action(ACT_INSERT, 5'(i), 32'(i * 7));
        send_action(ACT_INSERT, 5'd17, 32'hDEAD_BEEF);
        send_action(ACT_INSERT, 5'd1, 32'hDEAD_BEEF);
        send_action(ACT_READ, 5'd0, 32'd0);
        send_action(ACT_DELETE, 5'd17, 32'd0);
        send_action(ACT_DELETE, 5'd16, 32'd0);
        send_action(ACT_DELETE, 5'd1, 32'd0);
    endtask

    // Random actions weighted toward in-range positions so the list fills and drains.
    task automatic test_random(input int n);
        logic [1:0] act;
        logic [4:0] pos;
        int         r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 45) act = ACT_INSERT;
            else if (r < 80) act = ACT_DELETE;
            else if (r < 95) act = ACT_READ;
            else act = ACT_UNUSED;
            if ($urandom_range(0, 9) == 0) pos = 5'($urandom);
            else pos = 5'($urandom_range(1, list_len + 1));
            send_action(act, pos, $urandom);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        actions_sent = 0;
        list_len     = 0;
        stall_enable = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(170);
        // Final stretch runs without idling on either side.
        stall_enable = 1'b0;
        test_random(25);
        s_tvalid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Covered %0d actions and %0d output beats: insert, delete, read-out,",
                 actions_sent, beats_checked);
        $display("full, empty, out-of-range and unused-code cases.");
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
